// ===== src/cet_pkg.sv =====
package cet_pkg;

  localparam logic [11:0] BASE_YEAR    = 12'd2000;
  localparam logic [11:0] LAST_YEAR    = 12'd2099;
  localparam logic [6:0]  LAST_YR_OFS  = 7'd99;
  localparam logic [3:0]  MONTH_MAX    = 4'd12;
  localparam logic [3:0]  FEBRUARY     = 4'd2;
  localparam logic [4:0]  HOUR_MAX     = 5'd23;
  localparam logic [5:0]  MIN_SEC_MAX  = 6'd59;
  localparam logic [8:0]  DAYS_PER_YR  = 9'd365;
  localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
  localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SEC_PER_MIN  = 6'd60;
  localparam logic [4:0]  HOUR_PER_DAY = 5'd24;

  typedef struct packed {
    logic [11:0] start_year;
    logic [3:0]  start_month;
    logic [4:0]  start_day;
    logic [4:0]  start_hour;
    logic [5:0]  start_minute;
    logic [5:0]  start_second;
    logic [11:0] end_year;
    logic [3:0]  end_month;
    logic [4:0]  end_day;
    logic [4:0]  end_hour;
    logic [5:0]  end_minute;
    logic [5:0]  end_second;
  } req_t;

  typedef struct packed {
    logic [15:0] elapsed_days;
    logic [4:0]  elapsed_hours;
    logic [5:0]  elapsed_minutes;
    logic [5:0]  elapsed_seconds;
    logic [31:0] total_seconds;
    logic        end_before_start;
  } rsp_t;

  typedef struct packed {
    logic [6:0] yr;
    logic [3:0] mo;
    logic [4:0] dy;
    logic [4:0] hr;
    logic [5:0] mi;
    logic [5:0] se;
  } stamp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DAYS,
    ST_SOD,
    ST_MUL0,
    ST_MUL1,
    ST_SUM,
    ST_DIFF
  } state_t;

  typedef struct packed {
    logic load;
    logic calc_days;
    logic calc_sod;
    logic mul_first;
    logic mul_second;
    logic sum;
    logic write;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// ===== src/calendar_elapsed_time_unit.sv =====
// Elapsed time between two calendar date-times in 2000..2099. Each field is
// saturated to its range, then both stamps are turned into day and second
// counts by a short sequencer. A request is taken only while the sequencer is
// idle, so the next request waits until the last result has been written to
// the output register. The seven steps come from the controller walking
// clamp, day count, second-of-day, two passes through the shared 16x17
// seconds-per-day multiplier, the sum and the final borrow chain. The result
// sits in an output register, so the next request is taken while it waits;
// a new result that finds the register still full holds in the last step.
module calendar_elapsed_time_unit
  import cet_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  cmd_t    cmd;
  status_t stat;

  cet_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cet_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> (!rsp_valid || rsp_ready))
    else $error("result register overwritten before transfer");

  a_before_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.end_before_start) |->
      (rsp.total_seconds == 32'd0 && rsp.elapsed_days == 16'd0))
    else $error("end before start with nonzero counts");

  a_fields_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.elapsed_hours < HOUR_PER_DAY &&
                   rsp.elapsed_minutes < SEC_PER_MIN &&
                   rsp.elapsed_seconds < SEC_PER_MIN))
    else $error("elapsed field out of range");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !req_ready)
    else $error("request taken while busy");

endmodule

// ===== src/cet_ctrl.sv =====
module cet_ctrl
  import cet_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  status_t stat,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (req_valid) state_next = ST_DAYS;
      ST_DAYS: state_next = ST_SOD;
      ST_SOD:  state_next = ST_MUL0;
      ST_MUL0: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_SUM;
      ST_SUM:  state_next = ST_DIFF;
      ST_DIFF: if (stat.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      ST_DAYS: cmd.calc_days  = 1'b1;
      ST_SOD:  cmd.calc_sod   = 1'b1;
      ST_MUL0: cmd.mul_first  = 1'b1;
      ST_MUL1: cmd.mul_second = 1'b1;
      ST_SUM:  cmd.sum        = 1'b1;
      ST_DIFF: cmd.write      = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== src/cet_datapath.sv =====
module cet_datapath
  import cet_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  req_t    req,
  input  cmd_t    cmd,
  output status_t stat,
  output logic    rsp_valid,
  input  logic    rsp_ready,
  output rsp_t    rsp
);

  stamp_t      s0, s1;
  logic [15:0] days0, days1;
  logic [16:0] sod0, sod1;
  logic [31:0] t0, t1;
  logic [15:0] mul_a;
  logic [32:0] mul_p;

  function automatic logic [6:0] clamp_year(input logic [11:0] y);
    if (y < BASE_YEAR) return 7'd0;
    if (y > LAST_YEAR) return LAST_YR_OFS;
    return 7'(y - BASE_YEAR);
  endfunction

  function automatic logic [3:0] clamp_month(input logic [3:0] m);
    if (m == 4'd0) return 4'd1;
    if (m > MONTH_MAX) return MONTH_MAX;
    return m;
  endfunction

  function automatic logic [4:0] clamp_day(input logic [4:0] d);
    return (d == 5'd0) ? 5'd1 : d;
  endfunction

  function automatic logic [4:0] clamp_hour(input logic [4:0] h);
    return (h > HOUR_MAX) ? HOUR_MAX : h;
  endfunction

  function automatic logic [5:0] clamp_ms(input logic [5:0] v);
    return (v > MIN_SEC_MAX) ? MIN_SEC_MAX : v;
  endfunction

  function automatic logic [8:0] month_offset(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] stamp_days(input stamp_t s);
    logic [15:0] yr_days;
    logic [7:0]  leaps;
    logic        leap_add;
    yr_days  = 16'({9'd0, s.yr} * {7'd0, DAYS_PER_YR});
    leaps    = ({1'b0, s.yr} + 8'd3) >> 2;
    leap_add = (s.mo > FEBRUARY) && (s.yr[1:0] == 2'd0);
    return yr_days + 16'(leaps) + 16'(month_offset(s.mo)) + 16'(leap_add)
           + 16'(s.dy - 5'd1);
  endfunction

  function automatic logic [16:0] stamp_sod(input stamp_t s);
    return 17'({12'd0, s.hr} * {5'd0, SEC_PER_HOUR})
           + 17'({6'd0, s.mi} * {6'd0, SEC_PER_MIN}) + 17'(s.se);
  endfunction

  function automatic stamp_t clamp_start(input req_t r);
    stamp_t s;
    s.yr = clamp_year(r.start_year);
    s.mo = clamp_month(r.start_month);
    s.dy = clamp_day(r.start_day);
    s.hr = clamp_hour(r.start_hour);
    s.mi = clamp_ms(r.start_minute);
    s.se = clamp_ms(r.start_second);
    return s;
  endfunction

  function automatic stamp_t clamp_end(input req_t r);
    stamp_t s;
    s.yr = clamp_year(r.end_year);
    s.mo = clamp_month(r.end_month);
    s.dy = clamp_day(r.end_day);
    s.hr = clamp_hour(r.end_hour);
    s.mi = clamp_ms(r.end_minute);
    s.se = clamp_ms(r.end_second);
    return s;
  endfunction

  assign mul_a = cmd.mul_second ? days1 : days0;
  assign mul_p = {17'd0, mul_a} * {16'd0, SEC_PER_DAY};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s0 <= clamp_start(req);
      s1 <= clamp_end(req);
    end
    if (cmd.calc_days) begin
      days0 <= stamp_days(s0);
      days1 <= stamp_days(s1);
    end
    if (cmd.calc_sod) begin
      sod0 <= stamp_sod(s0);
      sod1 <= stamp_sod(s1);
    end
    if (cmd.mul_first) t0 <= mul_p[31:0];
    if (cmd.mul_second) t1 <= mul_p[31:0];
    if (cmd.sum) begin
      t0 <= t0 + 32'(sod0);
      t1 <= t1 + 32'(sod1);
    end
  end

  logic [6:0]  sec_d, min_d;
  logic [5:0]  hr_d;
  logic        b_sec, b_min, b_hr;
  logic [5:0]  sec_v, min_v;
  logic [4:0]  hr_v;
  logic [15:0] day_v;
  logic        end_early;

  always_comb begin
    sec_d = {1'b0, s1.se} - {1'b0, s0.se};
    b_sec = sec_d[6];
    sec_v = b_sec ? 6'(sec_d[5:0] + SEC_PER_MIN) : sec_d[5:0];
    min_d = {1'b0, s1.mi} - {1'b0, s0.mi} - 7'(b_sec);
    b_min = min_d[6];
    min_v = b_min ? 6'(min_d[5:0] + SEC_PER_MIN) : min_d[5:0];
    hr_d  = {1'b0, s1.hr} - {1'b0, s0.hr} - 6'(b_min);
    b_hr  = hr_d[5];
    hr_v  = b_hr ? 5'(hr_d[4:0] + HOUR_PER_DAY) : hr_d[4:0];
    day_v = days1 - days0 - 16'(b_hr);
    end_early = t1 < t0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.write) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      rsp.end_before_start <= end_early;
      rsp.elapsed_days     <= end_early ? 16'd0 : day_v;
      rsp.elapsed_hours    <= end_early ? 5'd0 : hr_v;
      rsp.elapsed_minutes  <= end_early ? 6'd0 : min_v;
      rsp.elapsed_seconds  <= end_early ? 6'd0 : sec_v;
      rsp.total_seconds    <= end_early ? 32'd0 : t1 - t0;
    end
  end

  assign stat.out_free = !rsp_valid || rsp_ready;

endmodule

// ===== tb/calendar_elapsed_time_check.sv =====
module calendar_elapsed_time_check
  import cet_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   mismatches,
  output int   outstanding
);

  rsp_t elapsed_q[$];
  int   bad_count = 0;

  function automatic int unsigned sat(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned days_before_month(int unsigned mo);
    case (mo)
      1:       return 0;
      2:       return 31;
      3:       return 59;
      4:       return 90;
      5:       return 120;
      6:       return 151;
      7:       return 181;
      8:       return 212;
      9:       return 243;
      10:      return 273;
      11:      return 304;
      default: return 334;
    endcase
  endfunction

  function automatic longint unsigned seconds_since_base(
    logic [11:0] y, logic [3:0] m, logic [4:0] d,
    logic [4:0] h, logic [5:0] mi, logic [5:0] s
  );
    int unsigned     yr, mo, dy, hr, mn, sc;
    longint unsigned days;
    yr = sat(y, BASE_YEAR, LAST_YEAR) - BASE_YEAR;
    mo = sat(m, 1, MONTH_MAX);
    dy = sat(d, 1, 31);
    hr = sat(h, 0, HOUR_MAX);
    mn = sat(mi, 0, MIN_SEC_MAX);
    sc = sat(s, 0, MIN_SEC_MAX);
    days = yr * 365 + (yr + 3) / 4 + days_before_month(mo) + dy - 1;
    if (mo > FEBRUARY && yr % 4 == 0) days = days + 1;
    return ((days * 24 + hr) * 60 + mn) * 60 + sc;
  endfunction

  function automatic rsp_t elapsed_between(req_t r);
    longint unsigned t0, t1, diff;
    rsp_t            e;
    t0 = seconds_since_base(r.start_year, r.start_month, r.start_day,
                            r.start_hour, r.start_minute, r.start_second);
    t1 = seconds_since_base(r.end_year, r.end_month, r.end_day,
                            r.end_hour, r.end_minute, r.end_second);
    e = '0;
    if (t1 < t0) begin
      e.end_before_start = 1'b1;
    end else begin
      diff = t1 - t0;
      e.elapsed_days    = 16'(diff / 86400);
      e.elapsed_hours   = 5'((diff % 86400) / 3600);
      e.elapsed_minutes = 6'((diff / 60) % 60);
      e.elapsed_seconds = 6'(diff % 60);
      e.total_seconds   = 32'(diff);
    end
    return e;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      elapsed_q.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (elapsed_q.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("unexpected result transfer: days %0d hms %0d:%0d:%0d total %0d flag %0b",
                     rsp.elapsed_days, rsp.elapsed_hours, rsp.elapsed_minutes,
                     rsp.elapsed_seconds, rsp.total_seconds, rsp.end_before_start);
        end else begin
          want = elapsed_q.pop_front();
          if (rsp.elapsed_days !== want.elapsed_days ||
              rsp.elapsed_hours !== want.elapsed_hours ||
              rsp.elapsed_minutes !== want.elapsed_minutes ||
              rsp.elapsed_seconds !== want.elapsed_seconds ||
              rsp.total_seconds !== want.total_seconds ||
              rsp.end_before_start !== want.end_before_start) begin
            bad_count++;
            if (bad_count <= 10) begin
              $display("mismatch expected: days %0d hms %0d:%0d:%0d total %0d flag %0b",
                       want.elapsed_days, want.elapsed_hours, want.elapsed_minutes,
                       want.elapsed_seconds, want.total_seconds, want.end_before_start);
              $display("           actual: days %0d hms %0d:%0d:%0d total %0d flag %0b",
                       rsp.elapsed_days, rsp.elapsed_hours, rsp.elapsed_minutes,
                       rsp.elapsed_seconds, rsp.total_seconds, rsp.end_before_start);
            end
          end
        end
      end
      if (req_valid && req_ready) elapsed_q.push_back(elapsed_between(req));
    end
    mismatches  <= bad_count;
    outstanding <= elapsed_q.size();
  end

endmodule

// ===== tb/tb_calendar_elapsed_time_unit.sv =====
module tb_calendar_elapsed_time_unit;
  import cet_pkg::*;

  localparam int NUM_RANDOM   = 500;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } moment_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;
  int   mismatches;
  int   outstanding;
  int   idle_cycles = 0;
  int   burst_left  = 0;
  int   stall_left  = 0;
  int   phase_left  = 0;
  int   stall_level = 0;

  calendar_elapsed_time_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  calendar_elapsed_time_check chk (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: calm stretches, light stalls and long stalls in random phases
  always @(posedge clk) begin
    if (phase_left == 0) begin
      phase_left  <= $urandom_range(50, 300);
      stall_level <= $urandom_range(0, 2);
    end else begin
      phase_left <= phase_left - 1;
    end
    if (stall_left != 0) begin
      rsp_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_level != 0 && $urandom_range(0, 3) == 0) begin
      rsp_ready  <= 1'b0;
      stall_left <= $urandom_range(0, (stall_level == 2) ? 24 : 3);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic moment_t at(int y, int mo, int d, int h, int mi, int s);
    moment_t m;
    m.year   = 12'(y);
    m.month  = 4'(mo);
    m.day    = 5'(d);
    m.hour   = 5'(h);
    m.minute = 6'(mi);
    m.second = 6'(s);
    return m;
  endfunction

  function automatic moment_t random_moment();
    return at($urandom_range(2000, 2099), $urandom_range(1, 12), $urandom_range(1, 31),
              $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
  endfunction

  function automatic req_t random_request();
    logic [95:0]  bits;
    moment_t      s, e, n;
    int unsigned  pick;
    pick = $urandom_range(0, 99);
    s = random_moment();
    e = random_moment();
    if (pick < 12) begin
      bits = {$urandom, $urandom, $urandom};
      return bits[75:0];
    end
    if (pick >= 90) begin
      e = s;
    end else if (pick >= 45) begin
      // end close to start: copy, then move a few fields
      e = s;
      repeat ($urandom_range(1, 3)) begin
        n = random_moment();
        case ($urandom_range(0, 5))
          0:       e.year   = n.year;
          1:       e.month  = n.month;
          2:       e.day    = n.day;
          3:       e.hour   = n.hour;
          4:       e.minute = n.minute;
          default: e.second = n.second;
        endcase
      end
    end
    return {s, e};
  endfunction

  task automatic send(input req_t r);
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 64) : $urandom_range(0, 15);
    end
  endtask

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    rsp_ready = 1'b0;
    burst_left = $urandom_range(0, 15);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send({at(2024, 6, 15, 12, 30, 45), at(2024, 6, 15, 12, 30, 45)});
    send({at(2024, 6, 15, 12, 30, 45), at(2024, 6, 15, 12, 30, 44)});
    send({at(2000, 1, 1, 0, 0, 0), at(2099, 12, 31, 23, 59, 59)});
    send({at(2099, 12, 31, 23, 59, 59), at(2000, 1, 1, 0, 0, 0)});
    send({at(2010, 3, 31, 23, 59, 59), at(2010, 4, 1, 0, 0, 0)});
    send({at(2004, 2, 28, 6, 0, 0), at(2004, 3, 1, 5, 59, 59)});
    send({at(2000, 2, 29, 0, 0, 0), at(2001, 2, 28, 0, 0, 0)});
    send({at(2001, 2, 1, 0, 0, 0), at(2001, 2, 31, 0, 0, 0)});
    send({at(0, 0, 0, 0, 0, 0), at(4095, 15, 31, 31, 63, 63)});
    send({at(4095, 15, 31, 31, 63, 63), at(0, 0, 0, 0, 0, 0)});
    send({at(2050, 5, 5, 30, 61, 62), at(2050, 5, 6, 0, 0, 0)});
    send({at(2099, 12, 31, 23, 59, 59), at(2100, 12, 31, 23, 59, 59)});
    send({at(2030, 12, 1, 0, 0, 0), at(2030, 13, 1, 0, 0, 0)});
    send({at(2077, 7, 7, 7, 7, 7), at(2077, 7, 7, 7, 7, 8)});
    send({at(2003, 12, 31, 23, 0, 0), at(2004, 1, 1, 1, 0, 0)});
    send({at(2048, 8, 16, 16, 32, 32), at(2063, 7, 15, 15, 31, 31)});

    repeat (NUM_RANDOM) send(random_request());
    req_valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
